FILE: src/pmpi_pkg.sv
// Shared widths, register codes and saturation helper for the penalty mass point integrator.
package pmpi_pkg;

  localparam int unsigned DIMENSIONS_DEF = 3;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int WORD_W    = 32;  // signed Q16.16 words
  localparam int UWORD_W   = 31;  // unsigned time step, stiffness, mass
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = 2;
  localparam int WIDE_W    = 64;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP = 2'd0,
    REG_GRAVITY_X = 2'd1,
    REG_GRAVITY_Y = 2'd2,
    REG_GRAVITY_Z = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_EULER    = 1'b0,
    MODE_MIDPOINT = 1'b1
  } mode_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic                     clip;
  } sat_t;

  // Clip a wide signed value to the 32-bit range.
  function automatic sat_t sat_word(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > WIDE_MAX) begin
      r.val  = WIDE_MAX[WORD_W-1:0];
      r.clip = 1'b1;
    end else if (v < WIDE_MIN) begin
      r.val  = WIDE_MIN[WORD_W-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[WORD_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: src/penalty_mass_point_integrator_top.sv
// Top level of the penalty spring mass point integrator: one coordinate update per transfer.
// Structure: the chain is 4 front stages, 32 stages of a restoring divider (one quotient bit
//   each) and 4 back stages. A result that the sink refuses waits in the output skid
//   register until the sink takes it.
// Throughput: one item per cycle while the skid register holds no untaken result,
//   set by the fully pipelined divider and multipliers.
// Reset (rst, synchronous, active high) clears all valid bits, the skid register and the
//   time step and gravity registers; payload registers are not reset.
module penalty_mass_point_integrator_top #(
  parameter int unsigned DIMENSIONS = pmpi_pkg::DIMENSIONS_DEF,
  parameter int unsigned FRAC_BITS  = pmpi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [pmpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmpi_pkg::WORD_W-1:0]          cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [pmpi_pkg::DIM_W-1:0]           dim_index,
  input  logic [pmpi_pkg::UWORD_W-1:0]         stiffness,
  input  logic [pmpi_pkg::UWORD_W-1:0]         mass,
  input  logic signed [pmpi_pkg::WORD_W-1:0]   struct_pos_old,
  input  logic signed [pmpi_pkg::WORD_W-1:0]   struct_pos_new,
  input  logic signed [pmpi_pkg::WORD_W-1:0]   point_pos_old,
  input  logic signed [pmpi_pkg::WORD_W-1:0]   point_pos_prov,
  input  logic signed [pmpi_pkg::WORD_W-1:0]   point_vel_old,
  input  logic signed [pmpi_pkg::WORD_W-1:0]   point_vel_prov,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pmpi_pkg::WORD_W-1:0]   point_pos_next,
  output logic signed [pmpi_pkg::WORD_W-1:0]   point_vel_next,
  output logic                                 saturated,
  output logic                                 zero_mass
);
  import pmpi_pkg::*;

  localparam int DIV_STEPS = WORD_W;  // quotient bits below the overflow check

  // ---------------------------------------------------------------------------
  // Configuration registers. Gravity has one entry per supported dimension;
  // writes to a gravity register beyond DIMENSIONS are dropped.
  // ---------------------------------------------------------------------------
  logic [UWORD_W-1:0]       time_step;
  logic signed [WORD_W-1:0] gravity [DIMENSIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= '0;
      for (int d = 0; d < DIMENSIONS; d++) gravity[d] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TIME_STEP) time_step <= cfg_data[UWORD_W-1:0];
      for (int d = 0; d < DIMENSIONS; d++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_GRAVITY_X) + d)) gravity[d] <= cfg_data;
      end
    end
  end

  logic signed [WORD_W:0] dt_s;  // time step as a non-negative signed operand
  assign dt_s = $signed({2'b00, time_step});

  // ---------------------------------------------------------------------------
  // Pipeline enable. The whole chain advances together unless the skid
  // register holds a result that the sink has not taken.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en       = ~skid_valid | out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // Stage A: averages for the midpoint rule, zero mass check.
  // ---------------------------------------------------------------------------
  logic signed [WORD_W:0]   sum_x, sum_y, sum_v;
  logic signed [WORD_W-1:0] xa_in, ya_in, va_in;

  always_comb begin
    sum_x = $signed({struct_pos_old[WORD_W-1], struct_pos_old})
          + $signed({struct_pos_new[WORD_W-1], struct_pos_new});
    sum_y = $signed({point_pos_old[WORD_W-1], point_pos_old})
          + $signed({point_pos_prov[WORD_W-1], point_pos_prov});
    sum_v = $signed({point_vel_old[WORD_W-1], point_vel_old})
          + $signed({point_vel_prov[WORD_W-1], point_vel_prov});
    if (req_type == MODE_MIDPOINT) begin
      // floor of half the sum: drop the low bit of the 33-bit sum
      xa_in = sum_x[WORD_W:1];
      ya_in = sum_y[WORD_W:1];
      va_in = sum_v[WORD_W:1];
    end else begin
      xa_in = struct_pos_old;
      ya_in = point_pos_old;
      va_in = point_vel_old;
    end
  end

  logic                     a_valid;
  logic signed [WORD_W-1:0] a_xa, a_ya, a_va, a_y0, a_v0;
  logic [UWORD_W-1:0]       a_k, a_m;
  logic [DIM_W-1:0]         a_dim;
  logic                     a_zm;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_xa  <= xa_in;
      a_ya  <= ya_in;
      a_va  <= va_in;
      a_y0  <= point_pos_old;
      a_v0  <= point_vel_old;
      a_k   <= stiffness;
      a_m   <= mass;
      a_dim <= dim_index;
      a_zm  <= (mass == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: displacement magnitude and sign, position product dt*v.
  // ---------------------------------------------------------------------------
  logic signed [WORD_W:0] disp, disp_neg;
  logic [WORD_W-1:0]      absd_in;
  logic                   neg_in;

  always_comb begin
    disp     = $signed({a_ya[WORD_W-1], a_ya}) - $signed({a_xa[WORD_W-1], a_xa});
    disp_neg = -disp;
    // |ya - xa| stays below 2^32, so the magnitude fits 32 bits
    absd_in  = disp[WORD_W] ? disp_neg[WORD_W-1:0] : disp[WORD_W-1:0];
    // a positive displacement pulls the acceleration negative
    neg_in   = ~disp[WORD_W] & (disp != '0);
  end

  logic                     b_valid;
  logic [WORD_W-1:0]        b_absd;
  logic                     b_neg;
  logic signed [WIDE_W-1:0] b_pos_prod;
  logic signed [WORD_W-1:0] b_y0, b_v0;
  logic [UWORD_W-1:0]       b_k, b_m;
  logic [DIM_W-1:0]         b_dim;
  logic                     b_zm;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_absd     <= absd_in;
      b_neg      <= neg_in;
      b_pos_prod <= WIDE_W'(dt_s * a_va);
      b_y0       <= a_y0;
      b_v0       <= a_v0;
      b_k        <= a_k;
      b_m        <= a_m;
      b_dim      <= a_dim;
      b_zm       <= a_zm;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: spring product k*|disp|, position sum and saturation.
  // ---------------------------------------------------------------------------
  logic signed [WIDE_W-1:0] pos_wide;
  sat_t                     pos_sat;

  always_comb begin
    pos_wide = $signed({{(WIDE_W-WORD_W){b_y0[WORD_W-1]}}, b_y0})
             + (b_pos_prod >>> FRAC_BITS);
    pos_sat  = sat_word(pos_wide);
  end

  logic                     c_valid;
  logic [WIDE_W-2:0]        c_mag;  // 31 x 32 bit product
  logic signed [WORD_W-1:0] c_pos, c_v0;
  logic                     c_pos_clip, c_neg, c_zm;
  logic [UWORD_W-1:0]       c_m;
  logic [DIM_W-1:0]         c_dim;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mag      <= (WIDE_W-1)'({32'd0, b_k} * {31'd0, b_absd});
      c_pos      <= pos_sat.val;
      c_pos_clip <= pos_sat.clip;
      c_v0       <= b_v0;
      c_neg      <= b_neg;
      c_zm       <= b_zm;
      c_m        <= b_m;
      c_dim      <= b_dim;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D (divider entry) and the divider steps. Index 0 of each array is
  // stage D; index s+1 is the register after quotient step s. If the high
  // word of the product is already at least m, the quotient reaches 2^32
  // and clips either way, so only 32 quotient bits are developed.
  // ---------------------------------------------------------------------------
  logic                     dv_valid    [DIV_STEPS+1];
  logic [UWORD_W-1:0]       dv_rem      [DIV_STEPS+1];
  logic [WORD_W-1:0]        dv_sh       [DIV_STEPS+1];  // dividend bits in, quotient bits out
  logic [UWORD_W-1:0]       dv_m        [DIV_STEPS+1];
  logic                     dv_big      [DIV_STEPS+1];
  logic                     dv_neg      [DIV_STEPS+1];
  logic                     dv_zm       [DIV_STEPS+1];
  logic signed [WORD_W-1:0] dv_pos      [DIV_STEPS+1];
  logic                     dv_pos_clip [DIV_STEPS+1];
  logic signed [WORD_W-1:0] dv_v0       [DIV_STEPS+1];
  logic [DIM_W-1:0]         dv_dim      [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else if (en) dv_valid[0] <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_big[0]      <= (c_mag[WIDE_W-2:WORD_W] >= c_m);
      dv_rem[0]      <= c_mag[WIDE_W-2:WORD_W];
      dv_sh[0]       <= c_mag[WORD_W-1:0];
      dv_m[0]        <= c_m;
      dv_neg[0]      <= c_neg;
      dv_zm[0]       <= c_zm;
      dv_pos[0]      <= c_pos;
      dv_pos_clip[0] <= c_pos_clip;
      dv_v0[0]       <= c_v0;
      dv_dim[0]      <= c_dim;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [WORD_W-1:0] trial;
    logic [WORD_W-1:0] diff;
    logic              fits;

    assign trial = {dv_rem[s], dv_sh[s][WORD_W-1]};
    assign diff  = trial - {1'b0, dv_m[s]};
    assign fits  = (trial >= {1'b0, dv_m[s]});

    always_ff @(posedge clk) begin
      if (rst) dv_valid[s+1] <= 1'b0;
      else if (en) dv_valid[s+1] <= dv_valid[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[s+1]      <= fits ? diff[UWORD_W-1:0] : trial[UWORD_W-1:0];
        dv_sh[s+1]       <= {dv_sh[s][WORD_W-2:0], fits};
        dv_m[s+1]        <= dv_m[s];
        dv_big[s+1]      <= dv_big[s];
        dv_neg[s+1]      <= dv_neg[s];
        dv_zm[s+1]       <= dv_zm[s];
        dv_pos[s+1]      <= dv_pos[s];
        dv_pos_clip[s+1] <= dv_pos_clip[s];
        dv_v0[s+1]       <= dv_v0[s];
        dv_dim[s+1]      <= dv_dim[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: signed acceleration from the quotient, clipped to 32 bits.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]        quot, quot_neg;
  logic signed [WORD_W-1:0] acc_in;
  logic                     acc_clip_in;

  always_comb begin
    quot     = dv_sh[DIV_STEPS];
    quot_neg = -quot;
    if (dv_neg[DIV_STEPS]) begin
      acc_clip_in = dv_big[DIV_STEPS] | (quot > {1'b1, {(WORD_W-1){1'b0}}});
      acc_in      = acc_clip_in ? WIDE_MIN[WORD_W-1:0] : quot_neg;
    end else begin
      acc_clip_in = dv_big[DIV_STEPS] | quot[WORD_W-1];
      acc_in      = acc_clip_in ? WIDE_MAX[WORD_W-1:0] : quot;
    end
  end

  logic                     e_valid;
  logic signed [WORD_W-1:0] e_acc, e_pos, e_v0;
  logic                     e_acc_clip, e_pos_clip, e_zm;
  logic [DIM_W-1:0]         e_dim;

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (en) e_valid <= dv_valid[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_acc      <= acc_in;
      e_acc_clip <= acc_clip_in;
      e_pos      <= dv_pos[DIV_STEPS];
      e_pos_clip <= dv_pos_clip[DIV_STEPS];
      e_v0       <= dv_v0[DIV_STEPS];
      e_zm       <= dv_zm[DIV_STEPS];
      e_dim      <= dv_dim[DIV_STEPS];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: add gravity of the selected dimension (zero past DIMENSIONS).
  // ---------------------------------------------------------------------------
  logic signed [WORD_W-1:0] g_sel;

  always_comb begin
    g_sel = '0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (e_dim == DIM_W'(d)) g_sel = gravity[d];
    end
  end

  logic                     f_valid;
  logic signed [WORD_W:0]   f_accg;
  logic signed [WORD_W-1:0] f_pos, f_v0;
  logic                     f_acc_clip, f_pos_clip, f_zm;

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (en) f_valid <= e_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_accg     <= $signed({e_acc[WORD_W-1], e_acc}) + $signed({g_sel[WORD_W-1], g_sel});
      f_acc_clip <= e_acc_clip;
      f_pos      <= e_pos;
      f_pos_clip <= e_pos_clip;
      f_v0       <= e_v0;
      f_zm       <= e_zm;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage G: velocity product dt*(a + g).
  // ---------------------------------------------------------------------------
  logic                     g_valid;
  logic signed [WIDE_W-1:0] g_prod;
  logic signed [WORD_W-1:0] g_pos, g_v0;
  logic                     g_acc_clip, g_pos_clip, g_zm;

  always_ff @(posedge clk) begin
    if (rst) g_valid <= 1'b0;
    else if (en) g_valid <= f_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_prod     <= WIDE_W'(dt_s * f_accg);
      g_acc_clip <= f_acc_clip;
      g_pos      <= f_pos;
      g_pos_clip <= f_pos_clip;
      g_v0       <= f_v0;
      g_zm       <= f_zm;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage H: velocity sum, saturation, zero mass pass-through, flag merge.
  // With zero mass only the position clip counts.
  // ---------------------------------------------------------------------------
  logic signed [WIDE_W-1:0] vel_wide;
  sat_t                     vel_sat;

  always_comb begin
    vel_wide = $signed({{(WIDE_W-WORD_W){g_v0[WORD_W-1]}}, g_v0}) + (g_prod >>> FRAC_BITS);
    vel_sat  = sat_word(vel_wide);
  end

  logic                     h_valid;
  logic signed [WORD_W-1:0] h_pos, h_vel;
  logic                     h_clip, h_zm;

  always_ff @(posedge clk) begin
    if (rst) h_valid <= 1'b0;
    else if (en) h_valid <= g_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_pos  <= g_pos;
      h_vel  <= g_zm ? g_v0 : vel_sat.val;
      h_clip <= g_pos_clip | (~g_zm & (g_acc_clip | vel_sat.clip));
      h_zm   <= g_zm;
    end
  end

  // ---------------------------------------------------------------------------
  // Output skid register. When the last stage shows a result the sink does not
  // take, the chain still advances and the result parks here; the chain
  // then holds until the sink takes it. While the skid is full and the sink
  // keeps taking, each new last-stage result moves into the skid.
  // ---------------------------------------------------------------------------
  logic signed [WORD_W-1:0] skid_pos, skid_vel;
  logic                     skid_clip, skid_zm;

  always_ff @(posedge clk) begin
    if (rst) skid_valid <= 1'b0;
    else if (en) skid_valid <= h_valid & (skid_valid | ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      skid_pos  <= h_pos;
      skid_vel  <= h_vel;
      skid_clip <= h_clip;
      skid_zm   <= h_zm;
    end
  end

  assign out_valid      = skid_valid | h_valid;
  assign point_pos_next = skid_valid ? skid_pos  : h_pos;
  assign point_vel_next = skid_valid ? skid_vel  : h_vel;
  assign saturated      = skid_valid ? skid_clip : h_clip;
  assign zero_mass      = skid_valid ? skid_zm   : h_zm;

endmodule

FILE: src/pmpi_checker.sv
// Port-level checks for the penalty mass point integrator, bound to the top level.
module pmpi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [pmpi_pkg::WORD_W-1:0] point_pos_next,
  input logic signed [pmpi_pkg::WORD_W-1:0] point_vel_next,
  input logic                               saturated,
  input logic                               zero_mass
);

  // reset empties the pipeline and the skid register
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a refused result holds until transferred
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_pos_next) &&
      $stable(point_vel_next) && $stable(saturated) && $stable(zero_mass))
    else $error("refused result changed or dropped");

  // a ready sink never back-pressures the input
  a_ready_follows_sink: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while sink ready");

  // with no result pending, the skid is empty and the input is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind penalty_mass_point_integrator_top pmpi_checker u_pmpi_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .point_pos_next (point_pos_next),
  .point_vel_next (point_vel_next),
  .saturated      (saturated),
  .zero_mass      (zero_mass)
);
